// ----- src/cwsc_pkg.sv -----
// Shared types and constants for the sparse convolution weight compressor.
package cwsc_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_IN_CHANNELS  = 2'd0,
        CFG_OUT_CHANNELS = 2'd1,
        CFG_KERNEL_SIZE  = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_ENTRY   = 2'd0,
        KIND_IC_END  = 2'd1,
        KIND_OC_END  = 2'd2,
        KIND_INVALID = 2'd3
    } kind_t;

    // Bit positions in the per-item result mask
    localparam int RES_ENTRY  = 0;
    localparam int RES_IC_END = 1;
    localparam int RES_OC_END = 2;
    localparam int RES_NUM    = 3;

    localparam int CFG_W      = 13;
    localparam int CHAN_W     = 12;
    localparam int KPOS_W     = 8;
    localparam int WORD_W     = 32;
    localparam int CHNZ_W     = 15;

    localparam logic [CFG_W-1:0]  CHAN_MAX = 13'd4096;
    localparam logic [CHNZ_W-1:0] CHNZ_SAT = 15'd32767;

    localparam int QUEUE_DEPTH_DEF = 4;

    // One classified item: which results it causes and their payloads
    typedef struct packed {
        logic [RES_NUM-1:0] res;
        logic [WORD_W-1:0]  value;
        logic [KPOS_W-1:0]  row;
        logic [KPOS_W-1:0]  col;
        logic [CHNZ_W-1:0]  chan_nz;
        logic [WORD_W-1:0]  total;
    } bundle_t;

endpackage

// ----- src/cwsc_front.sv -----
// Front end: configuration, position tracking and nonzero classification.
module cwsc_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [cwsc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cwsc_pkg::WORD_W-1:0]    weight_bits,
    input  logic                           q_full,
    output logic                           push,
    output cwsc_pkg::bundle_t              push_data
);

    logic [cwsc_pkg::CFG_W-1:0]  in_channels_reg;
    logic [cwsc_pkg::CFG_W-1:0]  out_channels_reg;
    logic [cwsc_pkg::KPOS_W-1:0] kernel_size_reg;

    logic [cwsc_pkg::KPOS_W-1:0] row_reg, row_next;
    logic [cwsc_pkg::KPOS_W-1:0] col_reg, col_next;
    logic [cwsc_pkg::CHAN_W-1:0] ic_reg, ic_next;
    logic [cwsc_pkg::CHAN_W-1:0] oc_reg, oc_next;
    logic [cwsc_pkg::CHNZ_W-1:0] chnz_reg, chnz_next, chnz_inc;
    logic [cwsc_pkg::WORD_W-1:0] total_reg, total_next, total_inc;

    logic [cwsc_pkg::KPOS_W-1:0] k_last;
    logic [cwsc_pkg::CHAN_W-1:0] ic_last;
    logic [cwsc_pkg::CHAN_W-1:0] oc_last;
    logic accept, nonzero, col_end, row_end, kern_end, ic_at_last, ic_end, oc_end;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_channels_reg  <= 13'd1;
            out_channels_reg <= 13'd1;
            kernel_size_reg  <= 8'd3;
        end
        else if (cfg_we)
        begin
            unique case (cwsc_pkg::cfg_index_t'(cfg_index))
                cwsc_pkg::CFG_IN_CHANNELS:  in_channels_reg  <= cfg_data;
                cwsc_pkg::CFG_OUT_CHANNELS: out_channels_reg <= cfg_data;
                cwsc_pkg::CFG_KERNEL_SIZE:  kernel_size_reg  <= cfg_data[cwsc_pkg::KPOS_W-1:0];
                default: ;
            endcase
        end
    end

    // Last indexes; zero acts as one, channels clamp at 4096
    always_comb
    begin
        k_last = (kernel_size_reg == '0) ? '0 : kernel_size_reg - 8'd1;
        if (in_channels_reg == '0)
            ic_last = '0;
        else if (in_channels_reg > cwsc_pkg::CHAN_MAX)
            ic_last = '1;
        else
            ic_last = cwsc_pkg::CHAN_W'(in_channels_reg - 13'd1);
        if (out_channels_reg == '0)
            oc_last = '0;
        else if (out_channels_reg > cwsc_pkg::CHAN_MAX)
            oc_last = '1;
        else
            oc_last = cwsc_pkg::CHAN_W'(out_channels_reg - 13'd1);
    end

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign nonzero    = |weight_bits[cwsc_pkg::WORD_W-2:0];
    assign col_end    = col_reg >= k_last;
    assign row_end    = row_reg >= k_last;
    assign kern_end   = col_end && row_end;
    assign ic_at_last = ic_reg >= ic_last;
    assign ic_end     = kern_end && ic_at_last;
    assign oc_end     = ic_end && (oc_reg >= oc_last);

    assign chnz_inc  = (nonzero && chnz_reg != cwsc_pkg::CHNZ_SAT) ? chnz_reg + 15'd1 : chnz_reg;
    assign total_inc = total_reg + {{(cwsc_pkg::WORD_W-1){1'b0}}, nonzero};

    always_comb
    begin
        chnz_next  = ic_end ? '0 : chnz_inc;
        total_next = oc_end ? '0 : total_inc;
        row_next   = row_reg;
        col_next   = col_reg;
        ic_next    = ic_reg;
        oc_next    = oc_reg;
        if (col_end)
        begin
            col_next = '0;
            if (row_end)
            begin
                row_next = '0;
                if (ic_at_last)
                begin
                    ic_next = '0;
                    oc_next = (oc_reg >= oc_last) ? '0 : oc_reg + 12'd1;
                end
                else
                begin
                    ic_next = ic_reg + 12'd1;
                end
            end
            else
            begin
                row_next = row_reg + 8'd1;
            end
        end
        else
        begin
            col_next = col_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            ic_reg    <= '0;
            oc_reg    <= '0;
            chnz_reg  <= '0;
            total_reg <= '0;
        end
        else if (accept)
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            ic_reg    <= ic_next;
            oc_reg    <= oc_next;
            chnz_reg  <= chnz_next;
            total_reg <= total_next;
        end
    end

    // Only items that cause results go to the queue
    assign push = accept && (nonzero || kern_end);

    always_comb
    begin
        push_data.res[cwsc_pkg::RES_ENTRY]  = nonzero;
        push_data.res[cwsc_pkg::RES_IC_END] = kern_end;
        push_data.res[cwsc_pkg::RES_OC_END] = ic_end;
        push_data.value   = weight_bits;
        push_data.row     = row_reg;
        push_data.col     = col_reg;
        push_data.chan_nz = chnz_inc;
        push_data.total   = total_inc;
    end

endmodule

// ----- src/cwsc_queue.sv -----
// Small FIFO of classified items between front and back end.
module cwsc_queue
#(
    parameter int DEPTH = cwsc_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  cwsc_pkg::bundle_t            push_data,
    input  logic                         pop,
    output cwsc_pkg::bundle_t            head,
    output logic                         full,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    cwsc_pkg::bundle_t  mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign level = count_reg;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

endmodule

// ----- src/cwsc_back.sv -----
// Back end: unpacks each queued item into its results, one per cycle while out_ready is high.
module cwsc_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cwsc_pkg::bundle_t            head,
    input  logic                         empty,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   kind,
    output logic [cwsc_pkg::WORD_W-1:0]  value_bits,
    output logic [cwsc_pkg::KPOS_W-1:0]  kernel_row,
    output logic [cwsc_pkg::KPOS_W-1:0]  kernel_col,
    output logic [cwsc_pkg::WORD_W-1:0]  offset,
    output logic                         last
);

    logic [cwsc_pkg::RES_NUM-1:0] done_reg, done_next;
    logic [cwsc_pkg::RES_NUM-1:0] rem, sel, rem_after;
    logic                         out_valid_reg, out_valid_next;
    cwsc_pkg::kind_t              kind_reg, kind_sel;
    logic [cwsc_pkg::WORD_W-1:0]  value_reg, value_sel;
    logic [cwsc_pkg::KPOS_W-1:0]  row_reg, row_sel;
    logic [cwsc_pkg::KPOS_W-1:0]  col_reg, col_sel;
    logic [cwsc_pkg::WORD_W-1:0]  offset_reg, offset_sel;
    logic                         last_reg, last_sel;
    logic                         load;

    assign load = !empty && (!out_valid_reg || out_ready);
    assign rem  = head.res & ~done_reg;

    // Results go out in order entry, input-channel end, output-channel end
    always_comb
    begin
        sel        = '0;
        kind_sel   = cwsc_pkg::KIND_OC_END;
        value_sel  = '0;
        row_sel    = '0;
        col_sel    = '0;
        offset_sel = head.total;
        if (rem[cwsc_pkg::RES_ENTRY])
        begin
            sel[cwsc_pkg::RES_ENTRY] = 1'b1;
            kind_sel   = cwsc_pkg::KIND_ENTRY;
            value_sel  = head.value;
            row_sel    = head.row;
            col_sel    = head.col;
            offset_sel = '0;
        end
        else if (rem[cwsc_pkg::RES_IC_END])
        begin
            sel[cwsc_pkg::RES_IC_END] = 1'b1;
            kind_sel   = cwsc_pkg::KIND_IC_END;
            offset_sel = cwsc_pkg::WORD_W'(head.chan_nz);
        end
        else
        begin
            sel[cwsc_pkg::RES_OC_END] = 1'b1;
        end
        rem_after = rem & ~sel;
        last_sel  = rem_after == '0;
    end

    assign pop = load && last_sel;

    always_comb
    begin
        done_next      = done_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            done_next      = last_sel ? '0 : (done_reg | sel);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind_sel;
            value_reg  <= value_sel;
            row_reg    <= row_sel;
            col_reg    <= col_sel;
            offset_reg <= offset_sel;
            last_reg   <= last_sel;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign value_bits = value_reg;
    assign kernel_row = row_reg;
    assign kernel_col = col_reg;
    assign offset     = offset_reg;
    assign last       = last_reg;

endmodule

// ----- src/conv_weight_sparse_compressor.sv -----
// Top level of the sparse (CSR-style) convolution weight compressor.
// Dense 32-bit float weights enter one per cycle in out-channel, in-channel,
// row, column order. The front end tracks the kernel position, tests each
// weight for zero (+0 and -0 both count as zero), keeps the per-channel
// (saturating at 32767) and total nonzero counts, and queues one record per
// weight that causes results. The back end turns each record into up to three
// results, one per cycle while out_ready is high: the nonzero entry with its
// kernel row and column, the channel count after each input-channel kernel,
// and the running total after each output channel. The input takes one weight
// every cycle while the QUEUE_DEPTH-entry queue has room; the output register
// delivers one result a cycle, so in_ready drops only when results pile up
// faster than out_ready drains them. Results pass the queue, then the output
// register. The user must write in_channels, out_channels and kernel_size
// via cfg_we/cfg_index/cfg_data only while the block is idle; the block does
// not enforce this. A zero acts as one; channel counts above 4096 act as 4096.
module conv_weight_sparse_compressor
#(
    parameter int QUEUE_DEPTH = cwsc_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [cwsc_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cwsc_pkg::WORD_W-1:0]  weight_bits,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   kind,
    output logic [cwsc_pkg::WORD_W-1:0]  value_bits,
    output logic [cwsc_pkg::KPOS_W-1:0]  kernel_row,
    output logic [cwsc_pkg::KPOS_W-1:0]  kernel_col,
    output logic [cwsc_pkg::WORD_W-1:0]  offset,
    output logic                         last
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    logic               push, pop, q_full, q_empty;
    logic [CNT_W-1:0]   q_level;
    cwsc_pkg::bundle_t  push_data, head;

    // Front: config, positions, classification
    cwsc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .weight_bits (weight_bits),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data)
    );

    // Decoupling queue
    cwsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty),
        .level     (q_level)
    );

    // Back: result serializer with output register
    cwsc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (q_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .value_bits (value_bits),
        .kernel_row (kernel_row),
        .kernel_col (kernel_col),
        .offset     (offset),
        .last       (last)
    );

    // Queue never overfills
    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= CNT_W'(QUEUE_DEPTH))
        else $error("queue level above depth");

    // An entry result always carries a nonzero weight
    a_entry_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == cwsc_pkg::KIND_ENTRY |-> value_bits[30:0] != '0)
        else $error("zero weight emitted as entry");

    // Output-channel end is always the final result of its item
    a_oc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == cwsc_pkg::KIND_OC_END |-> last)
        else $error("output-channel end not last");

    // Channel count stays within its saturated range
    a_chan_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == cwsc_pkg::KIND_IC_END |-> offset[31:15] == '0)
        else $error("channel count above saturation");

endmodule
